FILE: design/thermal_pixel_palette_mapper_defines.svh
// Assertion macros for the thermal pixel palette mapper checker.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef THERMAL_PIXEL_PALETTE_MAPPER_DEFINES_SVH
`define THERMAL_PIXEL_PALETTE_MAPPER_DEFINES_SVH

// same-cycle implication
`define TPPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/tppm_pkg.sv
// Shared widths, codes, types and the RGB565 packing function.
// No dependencies.
package tppm_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int CHAN_W      = 8;
	localparam int LEVEL_W     = 8;
	localparam int COLOUR_W    = 16;
	localparam int DIFF_W      = SAMPLE_W + 1;   // sample - lo, signed
	localparam int PROD_W      = DIFF_W + 8;     // diff * 254, signed
	localparam int MAG_W       = PROD_W - 1;     // |diff * 254| fits in 24 bits
	localparam int DMAG_W      = SAMPLE_W;       // |hi - lo|
	localparam int DIV_STAGES  = MAG_W;          // one quotient bit per stage
	localparam int RGB_W       = 3 * CHAN_W;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int SCALE = 254;
	localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(SCALE);

	localparam logic FUNC_MAP   = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RANGE_LOW   = 2'd0,
		REG_RANGE_HIGH  = 2'd1,
		REG_USE_PALETTE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] idx;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} entry_t;

	function automatic logic [COLOUR_W-1:0] pack565(input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		return {r[CHAN_W-1:3], g[CHAN_W-1:2], b[CHAN_W-1:3]};
	endfunction

endpackage

FILE: design/tppm_in_if.sv
// Item channel: valid/ready handshake with a sample or palette write payload.
// Depends on tppm_pkg.
interface tppm_in_if import tppm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                func;
	logic [SAMPLE_W-1:0] sample;
	logic [CHAN_W-1:0]   entry_index;
	logic [CHAN_W-1:0]   entry_red;
	logic [CHAN_W-1:0]   entry_green;
	logic [CHAN_W-1:0]   entry_blue;

	modport source (output valid, func, sample, entry_index, entry_red, entry_green,
		entry_blue, input ready);
	modport sink (input valid, func, sample, entry_index, entry_red, entry_green,
		entry_blue, output ready);
endinterface

FILE: design/tppm_out_if.sv
// Result channel: valid/ready handshake carrying an RGB565 colour and its level.
// Depends on tppm_pkg.
interface tppm_out_if import tppm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COLOUR_W-1:0] colour;
	logic [LEVEL_W-1:0]  level;

	modport source (output valid, colour, level, input ready);
	modport sink (input valid, colour, level, output ready);
endinterface

FILE: design/tppm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tppm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/thermal_pixel_palette_mapper.sv
// Top level of the thermal pixel palette mapper: scaling pipeline, palette RAM, output skid.
// Depends on tppm_pkg, tppm_in_if, tppm_out_if and tppm_ram.
//
// Takes one item per clock while the skid buffer is empty and returns one result per
// pixel item; palette writes travel the same pipeline and give no result. The window
// scaling is a signed division of the 25-bit scaled offset by the 17-bit window span,
// done as a 24-stage restoring divider that settles one quotient bit per stage, which
// sets the depth. Palette writes and reads hit the RAM at the same stage, in item order,
// so a pixel always sees every write that came before it. A one-entry skid buffer at
// the output keeps the pipeline moving for one more transaction when the result side
// stalls; ready drops only while that buffer is full. The window span is registered from
// the window registers, which a configuration write updates first.
module thermal_pixel_palette_mapper import tppm_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tppm_in_if.sink                item,
	tppm_out_if.source             result,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	// configuration, kept in derived form: lo = high + 2, hi = low + 1
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic                use_pal_q;
	logic [DMAG_W-1:0]   dmag_q;
	logic                dneg_q;
	logic                dzero_q;

	logic signed [DIFF_W-1:0] den_w;
	logic [DIFF_W-1:0]        den_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q      <= SAMPLE_W'(1);
			hi_q      <= SAMPLE_W'(1);
			use_pal_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_RANGE_LOW: begin
					hi_q <= SAMPLE_W'(cfg_wdata + CFG_DATA_W'(1));
				end
				REG_RANGE_HIGH: begin
					lo_q <= SAMPLE_W'(cfg_wdata + CFG_DATA_W'(2));
				end
				REG_USE_PALETTE: begin
					use_pal_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign den_w   = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
	assign den_abs = den_w[DIFF_W-1] ? DIFF_W'(-den_w) : DIFF_W'(den_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmag_q  <= '0;
			dneg_q  <= 1'b0;
			dzero_q <= 1'b1;
		end else begin
			dmag_q  <= den_abs[DMAG_W-1:0];
			dneg_q  <= den_w[DIFF_W-1];
			dzero_q <= (den_w == '0);
		end
	end

	// pipeline advance; frozen only while the skid buffer holds a result
	logic skid_v_q;
	logic en;

	assign en         = !skid_v_q;
	assign item.ready = en;

	// s1: offset from window start
	logic                     v_s1;
	logic                     func_s1;
	entry_t                   entry_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [DIFF_W-1:0] diff_w;

	assign diff_w = $signed({1'b0, item.sample}) - $signed({1'b0, lo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1  <= item.func;
			entry_s1 <= '{idx: item.entry_index, red: item.entry_red,
				green: item.entry_green, blue: item.entry_blue};
			diff_s1  <= diff_w;
		end
	end

	// s2: scale by 254
	logic                     v_s2;
	logic                     func_s2;
	entry_t                   entry_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W-1:0] diff_x;

	assign diff_x = PROD_W'(diff_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2  <= func_s1;
			entry_s2 <= entry_s1;
			prod_s2  <= diff_x * $signed(PROD_W'(SCALE));
		end
	end

	// divider: element 0 is stage s3 (magnitude and sign), element k is stage s(3+k)
	logic              v_sd    [DIV_STAGES+1];
	logic              func_sd [DIV_STAGES+1];
	logic              neg_sd  [DIV_STAGES+1];
	entry_t            entry_sd[DIV_STAGES+1];
	logic [DMAG_W-1:0] rem_sd  [DIV_STAGES+1];
	logic [MAG_W-1:0]  nq_sd   [DIV_STAGES+1];
	logic [PROD_W-1:0] prod_abs;

	assign prod_abs = prod_s2[PROD_W-1] ? PROD_W'(-prod_s2) : PROD_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_sd[0]  <= func_s2;
			entry_sd[0] <= entry_s2;
			neg_sd[0]   <= prod_s2[PROD_W-1];
			rem_sd[0]   <= '0;
			nq_sd[0]    <= prod_abs[MAG_W-1:0];
		end
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		logic [DMAG_W:0] trial;
		logic            take;

		// dividend bits shift out the top while quotient bits shift in below
		assign trial = {rem_sd[k-1], nq_sd[k-1][MAG_W-1]};
		assign take  = (trial >= {1'b0, dmag_q});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else if (en) begin
				v_sd[k] <= v_sd[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				func_sd[k]  <= func_sd[k-1];
				entry_sd[k] <= entry_sd[k-1];
				neg_sd[k]   <= neg_sd[k-1];
				rem_sd[k]   <= take ? DMAG_W'(trial - {1'b0, dmag_q}) : trial[DMAG_W-1:0];
				nq_sd[k]    <= {nq_sd[k-1][MAG_W-2:0], take};
			end
		end
	end

	// level = 254 - (q mod 256), or 254 for a zero window span; quotient sign applied on the low byte only
	logic [LEVEL_W-1:0] q_lo;
	logic               q_neg;
	logic [LEVEL_W-1:0] level_w;
	logic               last_v;
	logic               last_func;

	assign last_v    = v_sd[DIV_STAGES];
	assign last_func = func_sd[DIV_STAGES];
	assign q_lo      = nq_sd[DIV_STAGES][LEVEL_W-1:0];
	assign q_neg     = neg_sd[DIV_STAGES] ^ dneg_q;

	always_comb begin
		if (dzero_q) begin
			level_w = LEVEL_TOP;
		end else if (q_neg) begin
			level_w = LEVEL_TOP + q_lo;
		end else begin
			level_w = LEVEL_TOP - q_lo;
		end
	end

	// palette access, writes and reads in item order
	logic              pal_we;
	logic              pal_re;
	logic [RGB_W-1:0]  pal_rdata;
	entry_t            last_entry;

	assign last_entry = entry_sd[DIV_STAGES];
	assign pal_we     = en && last_v && (last_func == FUNC_WRITE);
	assign pal_re     = en && last_v && (last_func == FUNC_MAP);

	tppm_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(PAL_AW'(last_entry.idx)),
		.wdata({last_entry.red, last_entry.green, last_entry.blue}),
		.re   (pal_re),
		.raddr(PAL_AW'(level_w)),
		.rdata(pal_rdata)
	);

	// s28: level, palette data arrives with it
	logic               v_s28;
	logic               func_s28;
	logic [LEVEL_W-1:0] level_s28;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s28 <= 1'b0;
		end else if (en) begin
			v_s28 <= last_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s28  <= last_func;
			level_s28 <= level_w;
		end
	end

	// s29: colour packing, output register
	logic                v_s29;
	logic [COLOUR_W-1:0] colour_s29;
	logic [LEVEL_W-1:0]  level_s29;
	logic [COLOUR_W-1:0] colour_w;

	assign colour_w = use_pal_q
		? pack565(pal_rdata[RGB_W-1 -: CHAN_W], pal_rdata[2*CHAN_W-1 -: CHAN_W],
			pal_rdata[CHAN_W-1:0])
		: pack565(level_s28, level_s28, level_s28);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s29 <= 1'b0;
		end else if (en) begin
			v_s29 <= v_s28 && (func_s28 == FUNC_MAP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			colour_s29 <= colour_w;
			level_s29  <= level_s28;
		end
	end

	// skid buffer
	logic [COLOUR_W-1:0] colour_q;
	logic [LEVEL_W-1:0]  level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (!skid_v_q && v_s29 && !result.ready) begin
			skid_v_q <= 1'b1;
		end else if (skid_v_q && result.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			colour_q <= colour_s29;
			level_q  <= level_s29;
		end
	end

	assign result.valid  = skid_v_q || v_s29;
	assign result.colour = skid_v_q ? colour_q : colour_s29;
	assign result.level  = skid_v_q ? level_q : level_s29;

endmodule

FILE: design/tppm_checker.sv
// Port-level checker for the thermal pixel palette mapper, with its bind.
// Depends on tppm_pkg and thermal_pixel_palette_mapper_defines.svh.
`include "thermal_pixel_palette_mapper_defines.svh"

module tppm_checker import tppm_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   item_ready,
	input logic                   result_valid,
	input logic                   result_ready,
	input logic [COLOUR_W-1:0]    result_colour,
	input logic [LEVEL_W-1:0]     result_level,
	input logic                   cfg_wen,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0]  cfg_wdata
);

	// shadow of the window registers in derived form
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic                pal_q;
	logic [COLOUR_W-1:0] grey_colour;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q  <= SAMPLE_W'(1);
			hi_q  <= SAMPLE_W'(1);
			pal_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_RANGE_LOW: begin
					hi_q <= SAMPLE_W'(cfg_wdata + CFG_DATA_W'(1));
				end
				REG_RANGE_HIGH: begin
					lo_q <= SAMPLE_W'(cfg_wdata + CFG_DATA_W'(2));
				end
				REG_USE_PALETTE: begin
					pal_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign grey_colour = pack565(result_level, result_level, result_level);

	`TPPM_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result dropped before transaction")
	`TPPM_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result_colour) && $stable(result_level), "result payload changed while stalled")
	`TPPM_ASSERT_NOW(a_stall_cause, !item_ready, result_valid, "item side stalled with no pending result")
	`TPPM_ASSERT_NOW(a_grey_colour, result_valid && !pal_q, result_colour == grey_colour, "grey colour does not match level")
	`TPPM_ASSERT_NOW(a_zero_span, result_valid && (lo_q == hi_q), result_level == LEVEL_TOP, "zero window span must give top level")

endmodule

bind thermal_pixel_palette_mapper tppm_checker u_tppm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_colour(result.colour),
	.result_level (result.level),
	.cfg_wen      (cfg_wen),
	.cfg_index    (cfg_index),
	.cfg_wdata    (cfg_wdata)
);
